// File: sv/ssd_pkg.sv
// Shared beat types, command codes and decode tables for the seven-segment scan driver.
package ssd_pkg;

    // Command codes carried in the cmd field
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Scan phase that drives the decimal point line
    localparam logic [2:0] PHASE_DOT = 3'd7;

    // Number of digit enable lines on the result beat
    localparam int DIGIT_LINES = 4;

    // Reset value of the dot digit index: no dot
    localparam logic [3:0] DOT_NONE = 4'hF;

    // Reciprocals of powers of ten, ceil(2^32 / 10^k); exact for 16-bit dividends
    localparam logic [28:0] RECIP_E1 = 29'd429496730;
    localparam logic [28:0] RECIP_E2 = 29'd42949673;
    localparam logic [28:0] RECIP_E3 = 29'd4294968;
    localparam logic [28:0] RECIP_E4 = 29'd429497;

    // Input beat
    typedef struct packed {
        logic        cmd;
        logic [15:0] number;
        logic [3:0]  dot_position;
    } ssd_in_t;

    // Result beat
    typedef struct packed {
        logic [6:0] segment_lines;
        logic       dot_line;
        logic [3:0] digit_lines;
        logic [2:0] scan_phase;
        logic       pass_end;
    } ssd_out_t;

    // Quotient of a 16-bit value by 10^k; any k above four gives zero
    function automatic logic [15:0] pow10_quotient(input logic [15:0] x, input int k);
        logic [28:0] recip;
        logic [47:0] prod;
        logic [15:0] quot;
        case (k)
            1: begin
                recip = RECIP_E1;
            end
            2: begin
                recip = RECIP_E2;
            end
            3: begin
                recip = RECIP_E3;
            end
            4: begin
                recip = RECIP_E4;
            end
            default: begin
                recip = '0;
            end
        endcase
        prod = 48'(x) * 48'(recip);
        quot = (k == 0) ? x : prod[47:32];
        return quot;
    endfunction

    // Segment pattern of a decimal digit, bit 0 = a .. bit 6 = g
    function automatic logic [6:0] seg_decode(input logic [3:0] dec);
        logic [6:0] pat;
        case (dec)
            4'd0: begin
                pat = 7'h3F;
            end
            4'd1: begin
                pat = 7'h06;
            end
            4'd2: begin
                pat = 7'h5B;
            end
            4'd3: begin
                pat = 7'h4F;
            end
            4'd4: begin
                pat = 7'h66;
            end
            4'd5: begin
                pat = 7'h6D;
            end
            4'd6: begin
                pat = 7'h7D;
            end
            4'd7: begin
                pat = 7'h07;
            end
            4'd8: begin
                pat = 7'h7F;
            end
            4'd9: begin
                pat = 7'h6F;
            end
            default: begin
                pat = 7'h00;
            end
        endcase
        return pat;
    endfunction

endpackage

// File: sv/ssd_decimal_split.sv
// Decimal split of the loaded number: registered quotients, then digit decode and blanking.
module ssd_decimal_split
    import ssd_pkg::*;
#(
    parameter int DIGITS = 4
) (
    input  logic                     aclk,
    input  logic                     load_en,
    input  logic [15:0]              number,
    output logic [DIGITS-1:0][6:0]   patterns,
    output logic [DIGITS-1:0]        shown
);

    logic [DIGITS:0][15:0] quot_next;
    logic [DIGITS:0][15:0] quot_reg;
    logic [DIGITS-1:0][3:0] dec_digit;

    // Divide by each power of ten in parallel, one multiplier per place
    always_comb begin
        for (int k = 0; k <= DIGITS; k++) begin
            quot_next[k] = pow10_quotient(number, k);
        end
    end

    // Hold the quotients for the decode stage
    always_ff @(posedge aclk) begin
        if (load_en) begin
            quot_reg <= quot_next;
        end
    end

    // Take each digit as q(p) - 10 * q(p+1); leftmost digit is the highest place
    always_comb begin
        logic [15:0] tens;
        logic [15:0] diff;
        for (int p = 0; p < DIGITS; p++) begin
            tens = (quot_reg[p+1] << 3) + (quot_reg[p+1] << 1);
            diff = quot_reg[p] - tens;
            dec_digit[DIGITS-1-p] = diff[3:0];
        end
    end

    // Decode to segments and blank leading zeros, keeping the rightmost digit
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            patterns[i] = seg_decode(dec_digit[i]);
            seen        = seen | (dec_digit[i] != 4'd0);
            shown[i]    = seen;
        end
        shown[DIGITS-1] = 1'b1;
    end

endmodule

// File: sv/seven_segment_scan_driver.sv
// Top level of the multiplexed seven-segment scan driver: beat pipeline, display state, scan.
// A tick beat moves through the input, decode and result registers in turn.
// Throughput: one beat per cycle, loads and ticks alike, while the result channel accepts;
//   the per-place quotient multipliers sit between the input and decode registers.
// A load updates the display and restarts the scan; ticks behind it see the new state.
// Reset (aresetn low, synchronous): pipeline empties, digits blank, no dot, phase 0.
module seven_segment_scan_driver
    import ssd_pkg::*;
#(
    parameter int DIGITS = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ssd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output ssd_out_t m_data
);

    // Input stage
    logic    a_valid_reg;
    ssd_in_t a_item_reg;
    logic    a_go;

    // Decode stage
    logic       b_valid_reg;
    logic       b_cmd_reg;
    logic [3:0] b_dot_reg;
    logic       b_go;
    logic       b_load_go;
    logic       b_tick_go;

    // Result stage
    logic     m_valid_reg;
    ssd_out_t m_data_reg;
    ssd_out_t result_next;
    logic     out_free;

    // Display state
    logic [DIGITS-1:0][6:0] pattern_reg;
    logic [DIGITS-1:0]      shown_reg;
    logic [3:0]             dot_reg;
    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;

    logic [DIGITS-1:0][6:0] split_patterns;
    logic [DIGITS-1:0]      split_shown;

    logic [DIGIT_LINES-1:0] seg_hit;
    logic [DIGIT_LINES-1:0] dot_hit;

    // Flow control: a load in decode never waits, a tick waits for a free result slot
    assign out_free  = !m_valid_reg || m_ready;
    assign b_load_go = b_valid_reg && (b_cmd_reg == CMD_LOAD);
    assign b_tick_go = b_valid_reg && (b_cmd_reg == CMD_TICK) && out_free;
    assign b_go      = b_load_go || b_tick_go;
    assign a_go      = a_valid_reg && (!b_valid_reg || b_go);
    assign s_ready   = !a_valid_reg || a_go;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ssd_decimal_split #(
        .DIGITS (DIGITS)
    ) u_split (
        .aclk     (aclk),
        .load_en  (a_go),
        .number   (a_item_reg.number),
        .patterns (split_patterns),
        .shown    (split_shown)
    );

    // Per-line enables for the current phase; lines beyond the display stay off
    for (genvar b = 0; b < DIGIT_LINES; b++) begin : g_lines
        if (b < DIGITS) begin : g_used
            logic [7:0] pat_ext;
            assign pat_ext    = {1'b0, pattern_reg[b]};
            assign seg_hit[b] = shown_reg[b] & pat_ext[phase_reg];
            assign dot_hit[b] = (dot_reg == 4'(b));
        end else begin : g_unused
            assign seg_hit[b] = 1'b0;
            assign dot_hit[b] = 1'b0;
        end
    end

    // Form the tick result for the current phase
    always_comb begin
        result_next            = '0;
        result_next.scan_phase = phase_reg;
        if (phase_reg == PHASE_DOT) begin
            result_next.dot_line    = 1'b1;
            result_next.pass_end    = 1'b1;
            result_next.digit_lines = dot_hit;
        end else begin
            result_next.segment_lines = 7'd1 << phase_reg;
            result_next.digit_lines   = seg_hit;
        end
    end

    assign phase_next = phase_reg + 3'd1;

    // Control and display state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            pattern_reg <= '0;
            shown_reg   <= '0;
            dot_reg     <= DOT_NONE;
            phase_reg   <= 3'd0;
        end else begin
            // Advance the valid flags
            if (s_valid && s_ready) begin
                a_valid_reg <= 1'b1;
            end else if (a_go) begin
                a_valid_reg <= 1'b0;
            end
            if (a_go) begin
                b_valid_reg <= 1'b1;
            end else if (b_go) begin
                b_valid_reg <= 1'b0;
            end
            if (b_tick_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Load the display or step the scan
            if (b_load_go) begin
                pattern_reg <= split_patterns;
                shown_reg   <= split_shown;
                dot_reg     <= b_dot_reg;
                phase_reg   <= 3'd0;
            end else if (b_tick_go) begin
                phase_reg <= phase_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_item_reg <= s_data;
        end
        if (a_go) begin
            b_cmd_reg <= a_item_reg.cmd;
            b_dot_reg <= a_item_reg.dot_position;
        end
        if (b_tick_go) begin
            m_data_reg <= result_next;
        end
    end

    // A load leaving decode restarts the scan at phase 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_load_go |=> (phase_reg == 3'd0))
        else $error("scan not restarted by load");

    // A tick leaving decode advances the phase by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (b_tick_go && !b_load_go) |=> (phase_reg == 3'($past(phase_reg) + 3'd1)))
        else $error("scan phase did not advance on tick");

    // Segment phases light exactly one segment line and no dot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.scan_phase != PHASE_DOT)) |->
            ($onehot(m_data.segment_lines) && !m_data.dot_line && !m_data.pass_end))
        else $error("bad segment phase result");

    // The dot phase enables at most one digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.scan_phase == PHASE_DOT)) |->
            ($onehot0(m_data.digit_lines) && (m_data.segment_lines == 7'd0)))
        else $error("bad dot phase result");

    // Input is refused only while the input stage holds a beat that cannot move
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (a_valid_reg && b_valid_reg && !b_go))
        else $error("input stalled without cause");

endmodule

// File: sim/ssd_scan_checker.sv
// Scan checker: tracks the display state, predicts each tick's result beat and compares it.
`timescale 1ns / 1ps

module ssd_scan_checker
    import ssd_pkg::*;
#(
    parameter int DIGITS = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  ssd_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  ssd_out_t m_data,
    output int       mismatch_count,
    output int       pending_results
);

    // Segment patterns for 0..9, seven bits per digit, digit 0 in the low bits
    localparam logic [69:0] GLYPHS = {
        7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    // Display state as the block should hold it
    logic [6:0] glyph_of    [DIGITS];
    logic       digit_lit   [DIGITS];
    logic [3:0] dot_idx;
    logic [2:0] next_phase;

    ssd_out_t   scan_beats_due[$];
    int         errors;

    initial begin
        errors          = 0;
        mismatch_count  = 0;
        pending_results = 0;
    end

    // Split the number into decimal places, blank leading zeros, restart the scan
    task automatic apply_load(input logic [15:0] value, input logic [3:0] dot);
        int  rest;
        int  place;
        bit  seen;
        int  dec [DIGITS];
        rest = value;
        seen = 0;
        for (int i = DIGITS - 1; i >= 0; i--) begin
            dec[i] = rest % 10;
            rest   = rest / 10;
        end
        for (int i = 0; i < DIGITS; i++) begin
            place        = dec[i];
            glyph_of[i]  = GLYPHS[place * 7 +: 7];
            seen         = seen || (dec[i] != 0);
            digit_lit[i] = seen;
        end
        digit_lit[DIGITS - 1] = 1'b1;
        dot_idx    = dot;
        next_phase = '0;
    endtask

    // Work out the beat for the current phase, then advance the phase
    task automatic scan_tick(output ssd_out_t beat);
        logic [7:0] enables;
        enables = '0;
        if (next_phase != PHASE_DOT) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (digit_lit[d] && glyph_of[d][next_phase]) begin
                    enables[d] = 1'b1;
                end
            end
            beat.segment_lines = 7'(1 << next_phase);
            beat.dot_line      = 1'b0;
        end else begin
            if (dot_idx < DIGITS) begin
                enables[dot_idx] = 1'b1;
            end
            beat.segment_lines = '0;
            beat.dot_line      = 1'b1;
        end
        // Enables past the fourth digit do not fit the port
        beat.digit_lines = enables[DIGIT_LINES-1:0];
        beat.scan_phase  = next_phase;
        beat.pass_end    = (next_phase == PHASE_DOT);
        next_phase       = next_phase + 3'd1;
    endtask

    always @(posedge aclk) begin
        ssd_out_t due;
        ssd_out_t predicted;
        if (!aresetn) begin
            for (int d = 0; d < DIGITS; d++) begin
                glyph_of[d]  = '0;
                digit_lit[d] = 1'b0;
            end
            dot_idx    = DOT_NONE;
            next_phase = '0;
            scan_beats_due.delete();
        end else begin
            // Check the result beat first: it always belongs to an older input beat
            if (m_valid && m_ready) begin
                if (scan_beats_due.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_data);
                    errors++;
                end else begin
                    due = scan_beats_due.pop_front();
                    if (m_data.segment_lines !== due.segment_lines) begin
                        $error("segment_lines: expected %h, got %h",
                               due.segment_lines, m_data.segment_lines);
                        errors++;
                    end
                    if (m_data.dot_line !== due.dot_line) begin
                        $error("dot_line: expected %b, got %b",
                               due.dot_line, m_data.dot_line);
                        errors++;
                    end
                    if (m_data.digit_lines !== due.digit_lines) begin
                        $error("digit_lines: expected %b, got %b",
                               due.digit_lines, m_data.digit_lines);
                        errors++;
                    end
                    if (m_data.scan_phase !== due.scan_phase) begin
                        $error("scan_phase: expected %0d, got %0d",
                               due.scan_phase, m_data.scan_phase);
                        errors++;
                    end
                    if (m_data.pass_end !== due.pass_end) begin
                        $error("pass_end: expected %b, got %b",
                               due.pass_end, m_data.pass_end);
                        errors++;
                    end
                end
            end
            // Advance the display state on each input beat
            if (s_valid && s_ready) begin
                if (s_data.cmd == CMD_LOAD) begin
                    apply_load(s_data.number, s_data.dot_position);
                end else begin
                    scan_tick(predicted);
                    scan_beats_due.push_back(predicted);
                end
            end
        end
        mismatch_count  <= errors;
        pending_results <= scan_beats_due.size();
    end

endmodule

// File: sim/tb_top.sv
// Testbench top: clock, reset, load and tick stimulus with bursts and stalls, final verdict.
`timescale 1ns / 1ps

module tb_top;
    import ssd_pkg::*;

    localparam int NUM_DIGITS  = 4;
    localparam int RANDOM_BEATS = 550;
    localparam int CYCLE_LIMIT = 200000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ssd_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ssd_out_t m_data;

    int       mismatch_count;
    int       pending_results;
    int       burst_left;
    int       beats_sent;
    int       cycle_count;
    logic [7:0] rx_cycle  = '0;
    logic [1:0] rx_mode   = '0;

    seven_segment_scan_driver #(
        .DIGITS(NUM_DIGITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ssd_scan_checker #(
        .DIGITS(NUM_DIGITS)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stall the result channel; switch the stall style whenever the low six counter bits are zero
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (rx_cycle[5:0] == '0) begin
            rx_mode <= 2'($urandom_range(0, 3));
        end
        case (rx_mode)
            2'd0: begin
                m_ready <= 1'b1;
            end
            2'd1: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            2'd2: begin
                m_ready <= (rx_cycle[1:0] == 2'b11);
            end
            default: begin
                m_ready <= ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    // Drop the run if it hangs
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic ssd_in_t load_beat(input logic [15:0] value, input logic [3:0] dot);
        ssd_in_t beat;
        beat.cmd          = CMD_LOAD;
        beat.number       = value;
        beat.dot_position = dot;
        return beat;
    endfunction

    // Ticks carry random filler in the unused fields
    function automatic ssd_in_t tick_beat();
        ssd_in_t beat;
        beat.cmd          = CMD_TICK;
        beat.number       = 16'($urandom_range(0, 65535));
        beat.dot_position = 4'($urandom_range(0, 15));
        return beat;
    endfunction

    // Hold the beat on the channel until it is taken; open a new burst after a gap
    task automatic send_beat(input ssd_in_t beat);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        beats_sent++;
    endtask

    function automatic logic [15:0] pick_number();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 9));
            2: return 16'($urandom_range(0, 99));
            3: return 16'($urandom_range(0, 999));
            default: return 16'($urandom_range(0, 9999));
        endcase
    endfunction

    initial begin
        int ticks;
        burst_left = 0;
        beats_sent = 0;

        // Hold reset, then release it
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Blank display with no dot, through the phase wrap
        repeat (9) send_beat(tick_beat());
        // Zero: only the rightmost digit shows; dot sits on a blanked digit
        send_beat(load_beat(16'd0, 4'd0));
        repeat (8) send_beat(tick_beat());
        // Top value drops its fifth digit; no dot; reload mid-pass
        send_beat(load_beat(16'hFFFF, 4'hF));
        repeat (3) send_beat(tick_beat());
        send_beat(load_beat(16'd8, 4'd3));
        repeat (4) send_beat(tick_beat());
        // Dot index just past the last digit
        send_beat(load_beat(16'd9999, 4'd4));
        repeat (8) send_beat(tick_beat());

        // Random part: mostly a load followed by a run of ticks, some stray beats
        while (beats_sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 6) != 0) begin
                send_beat(load_beat(pick_number(),
                    ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, NUM_DIGITS))
                                               : 4'($urandom_range(0, 15))));
                ticks = $urandom_range(1, 12);
                repeat (ticks) send_beat(tick_beat());
            end else if ($urandom_range(0, 1) == 0) begin
                send_beat(tick_beat());
            end else begin
                send_beat(load_beat(16'($urandom_range(0, 65535)),
                                    4'($urandom_range(0, 15))));
            end
        end

        // Drain the results
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
